// ===== design/one_pkg.sv =====
package one_pkg;

	// Component width, fixed by the payload struct
	localparam int COMP_BITS = 16;
	// Magnitude of one component; the most negative value fits unsigned
	localparam int MAG_W = COMP_BITS;
	// s = |x|+|y|+|z| <= 3*2^(COMP_BITS-1)
	localparam int S_W = COMP_BITS + 1;
	// Offset numerator p = n+s <= 2s
	localparam int P_W = COMP_BITS + 2;
	// Divisor 2s
	localparam int D_W = COMP_BITS + 2;
	// Dividend 255p+s <= 511s
	localparam int N_W = COMP_BITS + 10;
	// Quotient bits, one per cell
	localparam int Q_W = 8;

	localparam logic [Q_W-1:0] CENTER_CODE = Q_W'(128);

	typedef struct packed {
		logic signed [COMP_BITS-1:0] normal_x;
		logic signed [COMP_BITS-1:0] normal_y;
		logic signed [COMP_BITS-1:0] normal_z;
	} norm_in_t;

	typedef struct packed {
		logic [Q_W-1:0] octa_x;
		logic [Q_W-1:0] octa_y;
	} octa_out_t;

	// Word handed from cell to cell
	typedef struct packed {
		logic [N_W-1:0] rem_x;
		logic [N_W-1:0] rem_y;
		logic [Q_W-1:0] quo_x;
		logic [Q_W-1:0] quo_y;
		logic [D_W-1:0] den;
		logic           zero;
	} cell_data_t;

endpackage

// ===== design/one_front.sv =====
module one_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               valid_in,
	input  one_pkg::norm_in_t  data_in,
	output logic               valid_out,
	output one_pkg::cell_data_t data_out
);
	import one_pkg::*;

	// p = n + s written as a sum of magnitudes, per component sign and fold
	function automatic logic [P_W-1:0] offset_num(
		input logic [MAG_W-1:0] a_self,
		input logic [MAG_W-1:0] a_other,
		input logic [MAG_W-1:0] a_z,
		input logic             neg_self,
		input logic             z_neg
	);
		logic [P_W-1:0] t_self;
		logic [P_W-1:0] t_z;
		t_self = neg_self ? '0 : (P_W'(a_self) << 1);
		if (z_neg) begin
			t_z = neg_self ? '0 : (P_W'(a_z) << 1);
		end else begin
			t_z = P_W'(a_z);
		end
		return t_self + P_W'(a_other) + t_z;
	endfunction

	logic             valid_s1, valid_s2, valid_s3;
	logic [MAG_W-1:0] ax_s1, ay_s1, az_s1;
	logic             sx_s1, sy_s1, zneg_s1;
	logic [S_W-1:0]   s_s2;
	logic [P_W-1:0]   px_s2, py_s2;
	logic             zero_s2;
	cell_data_t       data_s3;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage 1: magnitudes and signs
	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1   <= data_in.normal_x[COMP_BITS-1] ? MAG_W'(~data_in.normal_x + 1'b1)
			                                         : MAG_W'(data_in.normal_x);
			ay_s1   <= data_in.normal_y[COMP_BITS-1] ? MAG_W'(~data_in.normal_y + 1'b1)
			                                         : MAG_W'(data_in.normal_y);
			az_s1   <= data_in.normal_z[COMP_BITS-1] ? MAG_W'(~data_in.normal_z + 1'b1)
			                                         : MAG_W'(data_in.normal_z);
			sx_s1   <= data_in.normal_x[COMP_BITS-1];
			sy_s1   <= data_in.normal_y[COMP_BITS-1];
			zneg_s1 <= data_in.normal_z[COMP_BITS-1];
		end
	end

	// stage 2: L1 norm and offset numerators in parallel
	always_ff @(posedge clk) begin
		if (en) begin
			s_s2    <= S_W'(ax_s1) + S_W'(ay_s1) + S_W'(az_s1);
			px_s2   <= offset_num(ax_s1, ay_s1, az_s1, sx_s1, zneg_s1);
			py_s2   <= offset_num(ay_s1, ax_s1, az_s1, sy_s1, zneg_s1);
			zero_s2 <= ~|{ax_s1, ay_s1, az_s1};
		end
	end

	// stage 3: dividend 255p+s and divisor 2s
	always_ff @(posedge clk) begin
		if (en) begin
			data_s3.rem_x <= (N_W'(px_s2) << 8) - N_W'(px_s2) + N_W'(s_s2);
			data_s3.rem_y <= (N_W'(py_s2) << 8) - N_W'(py_s2) + N_W'(s_s2);
			data_s3.quo_x <= '0;
			data_s3.quo_y <= '0;
			data_s3.den   <= D_W'(s_s2) << 1;
			data_s3.zero  <= zero_s2;
		end
	end

	assign valid_out = valid_s3;
	assign data_out  = data_s3;

endmodule

// ===== design/one_cell.sv =====
module one_cell #(
	parameter int BIT_POS = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                valid_in,
	input  one_pkg::cell_data_t data_in,
	output logic                valid_out,
	output one_pkg::cell_data_t data_out
);
	import one_pkg::*;

	logic [N_W-1:0] den_sh;
	logic           take_x, take_y;
	logic           valid_s1;
	cell_data_t     data_s1;

	// one restoring step per lane against the divisor at this bit weight
	always_comb begin
		den_sh = N_W'(data_in.den) << BIT_POS;
		take_x = data_in.rem_x >= den_sh;
		take_y = data_in.rem_y >= den_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1.rem_x <= take_x ? data_in.rem_x - den_sh : data_in.rem_x;
			data_s1.rem_y <= take_y ? data_in.rem_y - den_sh : data_in.rem_y;
			data_s1.quo_x <= {data_in.quo_x[Q_W-2:0], take_x};
			data_s1.quo_y <= {data_in.quo_y[Q_W-2:0], take_y};
			data_s1.den   <= data_in.den;
			data_s1.zero  <= data_in.zero;
		end
	end

	assign valid_out = valid_s1;
	assign data_out  = data_s1;

endmodule

// ===== design/octahedral_normal_encode_top.sv =====
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_data  (norm_in_t: normal_x, normal_y, normal_z)
// out      output     out_valid / out_ready  out_data (octa_out_t: octa_x, octa_y)
//
// One vector per cycle sustained while the output is empty or taken; the pipeline is
// three front stages (magnitudes, L1 norm and numerators, dividend) and eight
// divider cells, one quotient bit each, both coordinates side by side.
// The whole pipeline advances when the output is empty or being taken.
// Reset clears only the valid bits; data registers are not reset.
module octahedral_normal_encode_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  one_pkg::norm_in_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output one_pkg::octa_out_t out_data
);
	import one_pkg::*;

	logic       en;
	logic       valid_c [0:Q_W];
	cell_data_t data_c  [0:Q_W];

	// global advance: last cell doubles as the output register
	assign en       = ~valid_c[Q_W] | out_ready;
	assign in_ready = en;

	one_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (in_valid),
		.data_in   (in_data),
		.valid_out (valid_c[0]),
		.data_out  (data_c[0])
	);

	// divider chain, MSB of the quotient first
	for (genvar i = 0; i < Q_W; i++) begin : g_cell
		one_cell #(
			.BIT_POS (Q_W - 1 - i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_in  (valid_c[i]),
			.data_in   (data_c[i]),
			.valid_out (valid_c[i+1]),
			.data_out  (data_c[i+1])
		);
	end

	// zero vector maps to the center code
	assign out_valid       = valid_c[Q_W];
	assign out_data.octa_x = data_c[Q_W].zero ? CENTER_CODE : data_c[Q_W].quo_x;
	assign out_data.octa_y = data_c[Q_W].zero ? CENTER_CODE : data_c[Q_W].quo_y;

endmodule

// ===== sim/testbench.sv =====
module testbench;
	import one_pkg::*;

	localparam int HALF_PERIOD = 2;
	localparam int RESET_CYCLES = 11;
	localparam int RANDOM_ITEMS = 1850;
	localparam int SETTLE_CYCLES = 24;
	localparam int CYCLE_LIMIT = 200000;
	// Final stretch of the run goes without any idling
	localparam int QUIET_TAIL = 250;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	norm_in_t  in_data;
	logic      out_valid;
	logic      out_ready;
	octa_out_t out_data;

	norm_in_t  pending_vectors[$];
	octa_out_t expected_codes[$];

	int  total_vectors = 0;
	int  sent_count = 0;
	int  drain_first = -1;
	int  drain_second = -1;
	int  error_count = 0;
	int  cycle_count = 0;
	int  send_gap = 0;
	int  sink_stall = 0;
	logic in_fire = 1'b0;
	logic idle_on;

	octahedral_normal_encode_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// Idling comes and goes in stretches of 150 vectors and stops near the end
	assign idle_on = ((sent_count / 150) % 3 != 0) &&
		(sent_count < total_vectors - QUIET_TAIL);

	// Round-half-up of 255*(n+s)/(2s), exact in integers
	function automatic logic [Q_W-1:0] quantize_coord(longint n, longint s);
		longint q;
		q = (510 * (n + s) + 2 * s) / (4 * s);
		if (q < 0) begin
			q = 0;
		end
		if (q > 255) begin
			q = 255;
		end
		return Q_W'(q);
	endfunction

	// Octahedral projection; lower hemisphere folded outward
	function automatic octa_out_t encode_normal(norm_in_t v);
		longint x, y, z, ax, ay, s, nx, ny;
		octa_out_t r;
		x = longint'($signed(v.normal_x));
		y = longint'($signed(v.normal_y));
		z = longint'($signed(v.normal_z));
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		s = ax + ay + ((z < 0) ? -z : z);
		nx = x;
		ny = y;
		if (s == 0) begin
			r.octa_x = CENTER_CODE;
			r.octa_y = CENTER_CODE;
			return r;
		end
		if (z < 0) begin
			nx = (x >= 0) ? (s - ay) : -(s - ay);
			ny = (y >= 0) ? (s - ax) : -(s - ax);
		end
		r.octa_x = quantize_coord(nx, s);
		r.octa_y = quantize_coord(ny, s);
		return r;
	endfunction

	function automatic logic [COMP_BITS-1:0] pick_component();
		int kind;
		logic [COMP_BITS-1:0] c;
		kind = $urandom_range(0, 9);
		if (kind < 5) begin
			c = COMP_BITS'($urandom());
		end else if (kind < 7) begin
			c = COMP_BITS'(int'($urandom_range(0, 16)) - 8);
		end else if (kind < 9) begin
			case ($urandom_range(0, 5))
				0: c = COMP_BITS'(-32768);
				1: c = COMP_BITS'(-32767);
				2: c = COMP_BITS'(-1);
				3: c = '0;
				4: c = COMP_BITS'(1);
				default: c = COMP_BITS'(32767);
			endcase
		end else begin
			// mid-size magnitudes of either sign
			c = COMP_BITS'($signed(COMP_BITS'($urandom())) >>> $urandom_range(1, 14));
		end
		return c;
	endfunction

	task automatic queue_vector(int x, int y, int z);
		norm_in_t v;
		v.normal_x = COMP_BITS'(x);
		v.normal_y = COMP_BITS'(y);
		v.normal_z = COMP_BITS'(z);
		pending_vectors.insert(pending_vectors.size(), v);
	endtask

	always #(HALF_PERIOD) clk = ~clk;

	// Input driver: new vector only once the previous one has transferred
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_fire) begin
				if ((sent_count == drain_first || sent_count == drain_second) &&
					expected_codes.size() != 0) begin
					in_valid <= 1'b0;
				end else if (send_gap > 0) begin
					in_valid <= 1'b0;
					send_gap = send_gap - 1;
				end else if (pending_vectors.size() != 0) begin
					in_data <= pending_vectors.pop_front();
					in_valid <= 1'b1;
					sent_count = sent_count + 1;
					if (idle_on && $urandom_range(0, 7) == 0) begin
						send_gap = $urandom_range(1, 5);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output back-pressure in short bursts
	always @(negedge clk) begin
		if (arst_n) begin
			if (sink_stall > 0) begin
				out_ready <= 1'b0;
				sink_stall = sink_stall - 1;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				sink_stall = $urandom_range(0, 4);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Monitor: predict on input transfer, compare on output transfer
	always @(posedge clk) begin
		octa_out_t want;
		in_fire <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			expected_codes.insert(expected_codes.size(), encode_normal(in_data));
		end
		if (out_valid && out_ready) begin
			if (expected_codes.size() == 0) begin
				error_count++;
				$display("%0t: unexpected result, actual %0d %0d", $time,
					out_data.octa_x, out_data.octa_y);
			end else begin
				want = expected_codes.pop_front();
				if (out_data.octa_x !== want.octa_x) begin
					error_count++;
					$display("%0t: octa_x expected %0d actual %0d", $time,
						want.octa_x, out_data.octa_x);
				end
				if (out_data.octa_y !== want.octa_y) begin
					error_count++;
					$display("%0t: octa_y expected %0d actual %0d", $time,
						want.octa_y, out_data.octa_y);
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		norm_in_t v;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		in_data = '0;

		// zero vector and single-axis extremes
		queue_vector(0, 0, 0);
		queue_vector(32767, 0, 0);
		queue_vector(-32768, 0, 0);
		queue_vector(0, 32767, 0);
		queue_vector(0, -32768, 0);
		queue_vector(0, 0, 32767);
		queue_vector(0, 0, -32768);
		// largest L1 norms, most negative values at full magnitude
		queue_vector(-32768, -32768, -32768);
		queue_vector(32767, 32767, 32767);
		queue_vector(32767, -32768, -32768);
		queue_vector(-32768, 32767, -1);
		// zero z: no fold
		queue_vector(100, -100, 0);
		queue_vector(-7, 3, 0);
		// fold with zero components counted as positive
		queue_vector(0, 0, -5);
		queue_vector(0, -3, -4);
		queue_vector(-3, 0, -4);
		queue_vector(1, 1, -1);
		queue_vector(-1, -1, -1);
		queue_vector(5, -7, -9);
		// unit steps and rounding near half
		queue_vector(1, 0, 0);
		queue_vector(-1, 0, 0);
		queue_vector(0, 0, 1);
		queue_vector(0, 0, -1);
		queue_vector(1, 1, 0);
		queue_vector(-1, 2, 1);
		drain_first = pending_vectors.size();
		drain_second = drain_first + RANDOM_ITEMS / 2;

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			v.normal_x = pick_component();
			v.normal_y = pick_component();
			v.normal_z = pick_component();
			pending_vectors.insert(pending_vectors.size(), v);
		end
		total_vectors = pending_vectors.size();

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_vectors.size() != 0 || in_valid || expected_codes.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (error_count == 0 && expected_codes.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
